### src/tbls_pkg.sv
// Package for the Thumb block load/store sequencer.
// Holds command, state and result codes plus list-scan helper functions.
// No dependencies.
`timescale 1ns / 1ps

package tbls_pkg;

  localparam int unsigned LIST_REGS = 8;
  localparam int unsigned REG_W     = 32;
  localparam int unsigned IDX_W     = 3;

  localparam logic [1:0] REQ_SET   = 2'd0;
  localparam logic [1:0] REQ_EXEC  = 2'd1;
  localparam logic [1:0] REQ_RDATA = 2'd2;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_REGW  = 2'd2;
  localparam logic [1:0] ACT_JUMP  = 2'd3;

  localparam logic [31:0] EMPTY_STRIDE = 32'h40;
  localparam logic [31:0] PC_OFFSET    = 32'd2;

  typedef enum logic [1:0] {
    CMD_SET,
    CMD_EXEC,
    CMD_RDATA
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   sel;
    logic [REG_W-1:0]   data;
    logic               load;
    logic [IDX_W-1:0]   rb;
    logic [LIST_REGS-1:0] list;
    logic [REG_W-1:0]   pc;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BASE,
    S_EMPTY_LD,
    S_EMPTY_ST,
    S_ST_W,
    S_ST_WB,
    S_LD_REQ,
    S_RD,
    S_LD_WB
  } back_state_t;

  function automatic logic [IDX_W-1:0] lowest_idx(input logic [LIST_REGS-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = LIST_REGS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [IDX_W:0] pop_count(input logic [LIST_REGS-1:0] v);
    logic [IDX_W:0] n;
    n = '0;
    for (int i = 0; i < LIST_REGS; i++) begin
      n = n + {{IDX_W{1'b0}}, v[i]};
    end
    return n;
  endfunction

endpackage

### src/tbls_front.sv
// Front end: accepts input beats, classifies them into commands and queues them.
// Uses tbls_pkg for the command struct and request codes.
`timescale 1ns / 1ps

module tbls_front #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          req_type,
  input  logic [2:0]          reg_select,
  input  logic [31:0]         data_value,
  input  logic [15:0]         instr_word,
  input  logic [31:0]         pc_value,
  output logic                cmd_valid,
  output tbls_pkg::cmd_t      cmd,
  input  logic                cmd_pop
);
  import tbls_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  cmd_t             queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  cmd_t             cmd_in;
  logic             known;
  logic             push;
  logic             pop;

  always_comb begin
    cmd_in.sel  = reg_select;
    cmd_in.data = data_value;
    cmd_in.load = instr_word[11];
    cmd_in.rb   = instr_word[10:8];
    cmd_in.list = instr_word[7:0];
    cmd_in.pc   = pc_value;
    known       = 1'b1;
    case (req_type)
      REQ_SET:   cmd_in.kind = CMD_SET;
      REQ_EXEC:  cmd_in.kind = CMD_EXEC;
      REQ_RDATA: cmd_in.kind = CMD_RDATA;
      default: begin
        cmd_in.kind = CMD_SET;
        known       = 1'b0;
      end
    endcase
  end

  assign in_stall  = (count == FULL_CNT);
  assign push      = in_valid && !in_stall && known;
  assign cmd_valid = (count != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### src/tbls_back.sv
// Back end: holds the low registers and the load state, runs each command
// and drives the registered result channel. Uses tbls_pkg.
`timescale 1ns / 1ps

module tbls_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  tbls_pkg::cmd_t  cmd,
  output logic            cmd_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      action,
  output logic [31:0]     address,
  output logic [31:0]     wdata,
  output logic [2:0]      dest_reg,
  output logic            last
);
  import tbls_pkg::*;

  back_state_t          state, state_next;
  logic [REG_W-1:0]     low_regs [LIST_REGS];
  logic [LIST_REGS-1:0] pending_list, pending_list_next;
  logic [IDX_W-1:0]     load_base_reg, load_base_reg_next;
  logic [REG_W-1:0]     load_end_address, load_end_address_next;
  logic                 jump_pending, jump_pending_next;

  logic                 wk_load, wk_load_next;
  logic [IDX_W-1:0]     wk_rb, wk_rb_next;
  logic [LIST_REGS-1:0] wk_list, wk_list_next;
  logic [IDX_W-1:0]     wk_first, wk_first_next;
  logic [REG_W-1:0]     wk_pc, wk_pc_next;
  logic [REG_W-1:0]     wk_data, wk_data_next;
  logic [REG_W-1:0]     wk_addr, wk_addr_next;
  logic [REG_W-1:0]     wk_end, wk_end_next;

  logic                 rf_we;
  logic [IDX_W-1:0]     rf_waddr;
  logic [REG_W-1:0]     rf_wdata;
  logic [IDX_W-1:0]     rf_raddr;
  logic [REG_W-1:0]     rf_rdata;

  logic                 out_free;
  logic                 out_load;
  logic [1:0]           o_action;
  logic [REG_W-1:0]     o_address;
  logic [REG_W-1:0]     o_wdata;
  logic [IDX_W-1:0]     o_dest;
  logic                 o_last;

  logic [IDX_W-1:0]     scan_idx;
  logic [LIST_REGS-1:0] list_left;
  logic [IDX_W-1:0]     pend_idx;
  logic [LIST_REGS-1:0] pend_left;
  logic [IDX_W:0]       cnt;
  logic [REG_W-1:0]     end_addr;

  assign out_free  = !out_valid || !out_stall;
  assign scan_idx  = lowest_idx(wk_list);
  assign list_left = wk_list & ~(LIST_REGS'(1) << scan_idx);
  assign pend_idx  = lowest_idx(pending_list);
  assign pend_left = pending_list & ~(LIST_REGS'(1) << pend_idx);
  assign cnt       = pop_count(wk_list);
  assign rf_raddr  = (state == S_BASE) ? wk_rb : scan_idx;
  assign rf_rdata  = low_regs[rf_raddr];
  assign end_addr  = (wk_list == '0) ? rf_rdata + EMPTY_STRIDE
                                     : rf_rdata + {{(REG_W-IDX_W-3){1'b0}}, cnt, 2'b00};

  always_comb begin
    state_next            = state;
    pending_list_next     = pending_list;
    load_base_reg_next    = load_base_reg;
    load_end_address_next = load_end_address;
    jump_pending_next     = jump_pending;
    wk_load_next          = wk_load;
    wk_rb_next            = wk_rb;
    wk_list_next          = wk_list;
    wk_first_next         = wk_first;
    wk_pc_next            = wk_pc;
    wk_data_next          = wk_data;
    wk_addr_next          = wk_addr;
    wk_end_next           = wk_end;
    cmd_pop               = 1'b0;
    rf_we                 = 1'b0;
    rf_waddr              = wk_rb;
    rf_wdata              = wk_end;
    out_load              = 1'b0;
    o_action              = ACT_WRITE;
    o_address             = '0;
    o_wdata               = '0;
    o_dest                = '0;
    o_last                = 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop      = 1'b1;
          wk_load_next = cmd.load;
          wk_rb_next   = cmd.rb;
          wk_list_next = cmd.list;
          wk_pc_next   = cmd.pc;
          wk_data_next = cmd.data;
          case (cmd.kind)
            CMD_SET: begin
              rf_we    = 1'b1;
              rf_waddr = cmd.sel;
              rf_wdata = cmd.data;
            end
            CMD_EXEC: begin
              if (pending_list == '0 && !jump_pending) begin
                state_next = S_BASE;
              end
            end
            CMD_RDATA: state_next = S_RD;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_BASE: begin
        wk_addr_next  = rf_rdata;
        wk_end_next   = end_addr;
        wk_first_next = scan_idx;
        if (wk_load) begin
          pending_list_next     = wk_list;
          load_base_reg_next    = wk_rb;
          load_end_address_next = end_addr;
          jump_pending_next     = (wk_list == '0);
        end
        if (wk_list == '0) begin
          state_next = wk_load ? S_EMPTY_LD : S_EMPTY_ST;
        end else begin
          state_next = wk_load ? S_LD_REQ : S_ST_W;
        end
      end
      S_EMPTY_LD: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_action   = ACT_READ;
          o_address  = wk_addr;
          o_last     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EMPTY_ST: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_action   = ACT_WRITE;
          o_address  = wk_addr;
          o_wdata    = wk_pc + PC_OFFSET;
          state_next = S_ST_WB;
        end
      end
      S_ST_W: begin
        if (out_free) begin
          out_load     = 1'b1;
          o_action     = ACT_WRITE;
          o_address    = wk_addr;
          o_wdata      = (scan_idx == wk_rb && scan_idx != wk_first) ? wk_end : rf_rdata;
          wk_list_next = list_left;
          wk_addr_next = wk_addr + 32'd4;
          if (list_left == '0) begin
            state_next = S_ST_WB;
          end
        end
      end
      S_ST_WB: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_action   = ACT_REGW;
          o_wdata    = wk_end;
          o_dest     = wk_rb;
          o_last     = 1'b1;
          rf_we      = 1'b1;
          rf_waddr   = wk_rb;
          rf_wdata   = wk_end;
          state_next = S_IDLE;
        end
      end
      S_LD_REQ: begin
        if (out_free) begin
          out_load     = 1'b1;
          o_action     = ACT_READ;
          o_address    = wk_addr;
          o_last       = (list_left == '0);
          wk_list_next = list_left;
          wk_addr_next = wk_addr + 32'd4;
          if (list_left == '0) begin
            state_next = S_IDLE;
          end
        end
      end
      S_RD: begin
        if (jump_pending) begin
          if (out_free) begin
            out_load          = 1'b1;
            o_action          = ACT_JUMP;
            o_address         = wk_data;
            jump_pending_next = 1'b0;
            state_next        = S_LD_WB;
          end
        end else if (pending_list != '0) begin
          if (out_free) begin
            out_load          = 1'b1;
            o_action          = ACT_REGW;
            o_wdata           = wk_data;
            o_dest            = pend_idx;
            o_last            = (pend_left != '0);
            rf_we             = 1'b1;
            rf_waddr          = pend_idx;
            rf_wdata          = wk_data;
            pending_list_next = pend_left;
            state_next        = (pend_left == '0) ? S_LD_WB : S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      S_LD_WB: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_action   = ACT_REGW;
          o_wdata    = load_end_address;
          o_dest     = load_base_reg;
          o_last     = 1'b1;
          rf_we      = 1'b1;
          rf_waddr   = load_base_reg;
          rf_wdata   = load_end_address;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      pending_list     <= '0;
      load_base_reg    <= '0;
      load_end_address <= '0;
      jump_pending     <= 1'b0;
      out_valid        <= 1'b0;
      for (int i = 0; i < LIST_REGS; i++) begin
        low_regs[i] <= '0;
      end
    end else begin
      state            <= state_next;
      pending_list     <= pending_list_next;
      load_base_reg    <= load_base_reg_next;
      load_end_address <= load_end_address_next;
      jump_pending     <= jump_pending_next;
      if (rf_we) begin
        low_regs[rf_waddr] <= rf_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wk_load  <= wk_load_next;
    wk_rb    <= wk_rb_next;
    wk_list  <= wk_list_next;
    wk_first <= wk_first_next;
    wk_pc    <= wk_pc_next;
    wk_data  <= wk_data_next;
    wk_addr  <= wk_addr_next;
    wk_end   <= wk_end_next;
    if (out_load) begin
      action   <= o_action;
      address  <= o_address;
      wdata    <= o_wdata;
      dest_reg <= o_dest;
      last     <= o_last;
    end
  end

endmodule

### src/thumb_block_load_store_sequencer_unit.sv
// Top level of the Thumb block load/store sequencer (LDMIA/STMIA).
// Joins tbls_front (classify and queue) and tbls_back (execute). Uses tbls_pkg.
//
//   channel | handshake            | beat carries
//   in      | in_valid / in_stall  | req_type reg_select data_value instr_word pc_value
//   out     | out_valid / out_stall| action address wdata dest_reg last
//
// Each command leaves the queue in the idle state. Execute then reads the base
// register and issues its results (up to 9); a dropped execute and a set
// register end with the pop. Read data issues its results after the pop
// (up to 2), or returns to idle when dropped. A stalled result holds its
// state. Reset clears the low registers and the load state; the queue absorbs
// QUEUE_DEPTH beats while the back end stalls.
`timescale 1ns / 1ps

module thumb_block_load_store_sequencer_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [2:0]  reg_select,
  input  logic [31:0] data_value,
  input  logic [15:0] instr_word,
  input  logic [31:0] pc_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  action,
  output logic [31:0] address,
  output logic [31:0] wdata,
  output logic [2:0]  dest_reg,
  output logic        last
);
  import tbls_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  tbls_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .reg_select (reg_select),
    .data_value (data_value),
    .instr_word (instr_word),
    .pc_value   (pc_value),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  tbls_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .action    (action),
    .address   (address),
    .wdata     (wdata),
    .dest_reg  (dest_reg),
    .last      (last)
  );

endmodule
